// ===== hdl/lphj_pkg.sv =====
// Shared types and constants for the linear probe hash join table.
// Used by the front end, the back end and the top level. No dependencies.
`default_nettype none
package lphj_pkg;
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_PROBE  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MATCH    = 3'd1;
  localparam logic [2:0] ST_NO_MATCH = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_RESERVED = 3'd4;

  localparam logic [31:0] EMPTY_MARK = 32'h8000_0000;
  localparam logic [31:0] MIX_C1     = 32'h85eb_ca6b;
  localparam logic [31:0] MIX_C2     = 32'hc2b2_ae35;
  localparam int unsigned MIN_BITS   = 4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] row;
    logic [31:0] hash;
  } job_t;
endpackage
`default_nettype wire

// ===== hdl/lphj_front.sv =====
// Front end: accepts items, drops kind three, computes the murmur3 finalizer
// in a short pipeline and pushes jobs into a two-entry queue. Uses lphj_pkg.
`default_nettype none
module lphj_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [1:0]     kind_i,
  input  wire logic [31:0]    key_i,
  input  wire logic [31:0]    row_index_i,
  output logic                job_valid_o,
  input  wire logic           job_ready_i,
  output lphj_pkg::job_t      job_o,
  output logic                busy_o
);
  logic [2:0] v_q, v_d;
  logic [1:0] k_q [3];
  logic [31:0] key_q [3];
  logic [31:0] row_q [3];
  logic [31:0] h_q [3];
  logic [31:0] h0, h1, h2;
  lphj_pkg::job_t fifo_q [2];
  logic [1:0] cnt_q;
  logic       rd_q, wr_q;
  logic       push, pop;

  assign h0 = key_i ^ (key_i >> 16);
  assign h1 = h_q[0] * lphj_pkg::MIX_C1;
  assign h2 = (h_q[1] ^ (h_q[1] >> 13)) * lphj_pkg::MIX_C2;

  // Input is accepted only when the queue has room for everything in flight plus the new item.
  assign in_ready = (32'(cnt_q) + 32'($countones(v_q))) < 32'd2;
  assign push     = v_q[2];
  assign pop      = job_valid_o && job_ready_i;
  assign job_valid_o = cnt_q != 2'd0;
  assign job_o    = fifo_q[rd_q];
  assign busy_o   = (v_q != 3'd0) || (cnt_q != 2'd0);

  always_comb begin
    v_d = {v_q[1:0], in_valid && in_ready && (kind_i != 2'd3)};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      cnt_q <= '0;
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
    end else begin
      v_q <= v_d;
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    k_q[0] <= kind_i; key_q[0] <= key_i; row_q[0] <= row_index_i; h_q[0] <= h0;
    k_q[1] <= k_q[0]; key_q[1] <= key_q[0]; row_q[1] <= row_q[0]; h_q[1] <= h1;
    k_q[2] <= k_q[1]; key_q[2] <= key_q[1]; row_q[2] <= row_q[1]; h_q[2] <= h2;
    if (push) begin
      fifo_q[wr_q] <= '{kind: k_q[2], key: key_q[2], row: row_q[2],
                        hash: h_q[2] ^ (h_q[2] >> 16)};
    end
  end
endmodule
`default_nettype wire

// ===== hdl/lphj_back.sv =====
// Back end: walks the slot memory for inserts and probes, sweeps it on a
// clear and drives the result register. Uses lphj_pkg.
`default_nettype none
module lphj_back #(
  parameter int unsigned SLOT_COUNT  = 1024,
  parameter int unsigned MAX_MATCHES = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic [3:0]     table_bits_i,
  input  wire logic           job_valid_i,
  output logic                job_ready_o,
  input  wire lphj_pkg::job_t job_i,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [2:0]          status_o,
  output logic [31:0]         build_index_o,
  output logic [31:0]         probe_index_o,
  output logic                truncated_o,
  output logic                last_o,
  output logic                busy_o
);
  localparam int unsigned AW = $clog2(SLOT_COUNT);
  localparam int unsigned MW = $clog2(MAX_MATCHES + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EVAL = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [31:0] mem_key [SLOT_COUNT];
  logic [31:0] mem_row [SLOT_COUNT];
  logic [31:0] rd_key_q, rd_row_q;
  logic [AW-1:0] pos_q, mask;
  logic [AW:0] size, steps_q, occ_q;
  logic [MW-1:0] found_q;
  lphj_pkg::job_t job_q;
  logic [4:0] bits_c;
  logic sweep_q;
  logic [AW:0] sweep_cnt_q;
  logic [31:0] hold_row_q;
  logic have_match;
  logic accept, out_free;
  logic wr_en, advance, take_match;
  logic [2:0] st_r;
  logic [31:0] bi_r;
  logic tr_r, la_r;
  logic load_out;

  always_comb begin
    bits_c = {1'b0, table_bits_i};
    if (bits_c < 5'(lphj_pkg::MIN_BITS)) bits_c = 5'(lphj_pkg::MIN_BITS);
    if (bits_c > 5'(AW)) bits_c = 5'(AW);
    size = (AW+1)'(1) << bits_c;
    mask = AW'(size - (AW+1)'(1));
  end

  assign job_ready_o = (state_q == S_IDLE) && !sweep_q;
  assign busy_o = (state_q != S_IDLE) || sweep_q || out_valid;
  assign accept = job_valid_i && job_ready_o;
  assign out_free = !out_valid || out_ready;
  assign have_match = found_q != '0;

  // The most recent match is held back until the walk shows whether it is
  // the last one of the probe.
  always_comb begin
    state_d = state_q; load_out = 1'b0; wr_en = 1'b0; advance = 1'b0;
    take_match = 1'b0;
    st_r = lphj_pkg::ST_OK; bi_r = '0; tr_r = 1'b0; la_r = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (job_i.kind == lphj_pkg::KIND_CLEAR) state_d = S_EMIT;
          else if (job_i.kind == lphj_pkg::KIND_INSERT &&
                   job_i.key == lphj_pkg::EMPTY_MARK) state_d = S_EMIT;
          else if (job_i.kind == lphj_pkg::KIND_INSERT &&
                   (occ_q + (AW+1)'(2)) > size) state_d = S_EMIT;
          else state_d = S_READ;
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        if (job_q.kind == lphj_pkg::KIND_INSERT) begin
          if (rd_key_q == lphj_pkg::EMPTY_MARK) begin
            if (out_free) begin
              wr_en = 1'b1; load_out = 1'b1; state_d = S_IDLE;
            end
          end else if (steps_q == (AW+1)'(1)) begin
            if (out_free) begin
              load_out = 1'b1; st_r = lphj_pkg::ST_FULL; state_d = S_IDLE;
            end
          end else begin
            advance = 1'b1; state_d = S_READ;
          end
        end else if (rd_key_q == lphj_pkg::EMPTY_MARK || steps_q == '0) begin
          if (out_free) begin
            load_out = 1'b1; state_d = S_IDLE;
            if (have_match) begin
              st_r = lphj_pkg::ST_MATCH; bi_r = hold_row_q;
            end else st_r = lphj_pkg::ST_NO_MATCH;
          end
        end else if (rd_key_q == job_q.key) begin
          if (found_q == MW'(MAX_MATCHES)) begin
            if (out_free) begin
              load_out = 1'b1; st_r = lphj_pkg::ST_MATCH; bi_r = hold_row_q;
              tr_r = 1'b1; state_d = S_IDLE;
            end
          end else if (!have_match || out_free) begin
            take_match = 1'b1; advance = 1'b1; state_d = S_READ;
            if (have_match) begin
              load_out = 1'b1; st_r = lphj_pkg::ST_MATCH; bi_r = hold_row_q;
              la_r = 1'b0;
            end
          end
        end else begin
          advance = 1'b1; state_d = S_READ;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          load_out = 1'b1; state_d = S_IDLE;
          if (job_q.kind == lphj_pkg::KIND_CLEAR) st_r = lphj_pkg::ST_OK;
          else if (job_q.key == lphj_pkg::EMPTY_MARK) st_r = lphj_pkg::ST_RESERVED;
          else st_r = lphj_pkg::ST_FULL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; occ_q <= '0; sweep_q <= 1'b1; sweep_cnt_q <= '0;
      out_valid <= 1'b0; found_q <= '0; steps_q <= '0; pos_q <= '0;
      last_o <= 1'b0; truncated_o <= 1'b0; status_o <= '0;
    end else begin
      state_q <= state_d;
      if (sweep_q) begin
        sweep_cnt_q <= sweep_cnt_q + (AW+1)'(1);
        if (sweep_cnt_q == (AW+1)'(SLOT_COUNT - 1)) sweep_q <= 1'b0;
      end else if (accept && job_i.kind == lphj_pkg::KIND_CLEAR) begin
        sweep_q <= 1'b1; sweep_cnt_q <= '0;
      end
      if (load_out) begin
        out_valid <= 1'b1; status_o <= st_r; last_o <= la_r; truncated_o <= tr_r;
      end else if (out_ready) out_valid <= 1'b0;
      if (accept) begin
        pos_q <= job_i.hash[AW-1:0] & mask;
        steps_q <= size; found_q <= '0;
        if (job_i.kind == lphj_pkg::KIND_CLEAR) occ_q <= '0;
      end else begin
        if (wr_en) occ_q <= occ_q + (AW+1)'(1);
        if (advance) begin
          pos_q <= (pos_q + AW'(1)) & mask;
          steps_q <= steps_q - (AW+1)'(1);
        end
        if (take_match) found_q <= found_q + MW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) job_q <= job_i;
    if (take_match) hold_row_q <= rd_row_q;
    if (load_out) begin
      build_index_o <= bi_r;
      probe_index_o <= job_q.row;
    end
    if (sweep_q) mem_key[sweep_cnt_q[AW-1:0]] <= lphj_pkg::EMPTY_MARK;
    else if (wr_en) begin
      mem_key[pos_q] <= job_q.key;
      mem_row[pos_q] <= job_q.row;
    end
    rd_key_q <= mem_key[pos_q];
    rd_row_q <= mem_row[pos_q];
  end
endmodule
`default_nettype wire

// ===== hdl/linear_probe_hash_join_table_unit.sv =====
// Top level of the linear probe hash join table: configuration register,
// front end and back end. Depends on lphj_pkg, lphj_front and lphj_back.
//
// The block takes items of kind clear, insert or probe on the in channel and
// returns result beats on the out channel, each carrying status, build and
// probe indices, a truncated flag and a last flag. The cfg channel writes the
// log2 table size; a write is taken only while the block is idle.
// An item passes through the hash pipeline and then the queue of the front
// end before the back end takes it. The back end then walks the slot memory,
// visiting each slot with a memory read and then a compare. An insert or
// probe occupies the back end until its walk ends; a clear starts a sweep of
// the whole memory, one slot a cycle, before the next job is taken.
// A stalled receiver holds the result register; a probe keeps one further
// match in a hold register and then stops its walk, while the front end
// keeps accepting up to two items. After reset the block sweeps the whole
// slot memory before it takes its first job.
`default_nettype none
module linear_probe_hash_join_table_unit #(
  parameter int unsigned SLOT_COUNT  = 1024,
  parameter int unsigned MAX_MATCHES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  table_bits_i,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] key_i,
  input  wire logic [31:0] row_index_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status_o,
  output logic [31:0]      build_index_o,
  output logic [31:0]      probe_index_o,
  output logic             truncated_o,
  output logic             last_o
);
  logic [3:0] bits_q;
  logic job_valid, job_ready, fbusy, bbusy;
  lphj_pkg::job_t job;

  assign cfg_ready = !(fbusy || bbusy);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bits_q <= 4'd10;
    else if (cfg_valid && cfg_ready) bits_q <= table_bits_i;
  end

  lphj_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .kind_i, .key_i, .row_index_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job), .busy_o(fbusy)
  );

  lphj_back #(.SLOT_COUNT(SLOT_COUNT), .MAX_MATCHES(MAX_MATCHES)) u_back (
    .clk_i, .rst_ni, .table_bits_i(bits_q), .job_valid_i(job_valid),
    .job_ready_o(job_ready), .job_i(job), .out_valid, .out_ready, .status_o,
    .build_index_o, .probe_index_o, .truncated_o, .last_o, .busy_o(bbusy)
  );
endmodule
`default_nettype wire

// ===== hdl/lphj_checker.sv =====
// Port checker for the linear probe hash join table unit, bound to the top.
// Depends on the top level's ports and on lphj_pkg for status codes.
`default_nettype none
module lphj_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status_o,
  input wire logic [31:0] build_index_o,
  input wire logic        truncated_o,
  input wire logic        last_o
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(status_o) &&
    $stable(build_index_o) && $stable(last_o))
    else $error("out beat dropped");
  a_trunc_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && truncated_o |-> last_o) else $error("truncated without last");
  a_nonmatch_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status_o != lphj_pkg::ST_MATCH |-> last_o)
    else $error("non-match not last");
  a_build_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status_o != lphj_pkg::ST_MATCH |-> build_index_o == 32'd0)
    else $error("build index not zero");
endmodule

bind linear_probe_hash_join_table_unit lphj_checker u_lphj_checker (
  .clk_i, .rst_ni, .out_valid, .out_ready, .status_o, .build_index_o,
  .truncated_o, .last_o
);
`default_nettype wire
